// ===== rtl/rbi_pkg.sv =====
// Shared types, status codes and saturation helpers for the 2-D rigid body integrator.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
`timescale 1ns / 1ps

package rbi_pkg;

   // Number of axes handled side by side: x, y and rotation
   localparam int unsigned LANES      = 3;
   // Quotient bits produced by the divider pipeline, one per stage
   localparam int unsigned DIV_STAGES = 32;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ZERO = 2'd1;
   localparam logic [1:0] STAT_SAT  = 2'd2;

   localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      logic               op;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] angle;
      logic signed [31:0] ang_rate;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] net_torque;
      logic [30:0]        body_mass;
      logic [30:0]        body_inertia;
   } req_type;

   typedef struct packed {
      logic signed [31:0] next_pos_x;
      logic signed [31:0] next_pos_y;
      logic signed [31:0] next_vel_x;
      logic signed [31:0] next_vel_y;
      logic signed [31:0] next_angle;
      logic signed [31:0] next_ang_rate;
      logic [1:0]         status;
   } rsp_type;

   // Classified body as it waits between front and back; lane 0 x, 1 y, 2 rotation
   typedef struct packed {
      logic                   op;
      logic                   zero;
      logic [2:0][31:0]       pos;
      logic [2:0][31:0]       vel;
      logic [2:0][31:0]       load_mag;
      logic [2:0]             load_neg;
      logic [2:0][30:0]       divisor;
      logic [2:0]             div_zero;
   } job_type;

   // State that rides alongside the dividers
   typedef struct packed {
      logic             op;
      logic             zero;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
   } carry_type;

   // Clamp a wide signed value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // True when sat32 would clamp
   function automatic logic ovf32(input logic signed [63:0] v);
      return (v > S32_MAX) || (v < S32_MIN);
   endfunction

endpackage

// ===== rtl/rigid_body_2d_integrator_top.sv =====
// Top level of the planar rigid body integrator: step register, front, queue and back.
// Depends on rbi_pkg, rbi_front, rbi_queue and rbi_back.
//
//   port group   direction   handshake            payload
//   req_         in          req_push / req_full   rbi_pkg::req_type
//   rsp_         out         rsp_pop / rsp_empty   rbi_pkg::rsp_type
//   csr_         in          csr_we                time_step (31 bits)
//
// One body enters per cycle while req_full is low; a result that nothing stalls
// passes through one front register, the queue, 33 divider stages and five
// multiply, shift and clamp stages. The divider pipeline sets the latency.
// Reset empties the pipe and loads a step of 1092. A held result freezes the
// back pipe; the queue of QUEUE_DEPTH entries and the front register absorb input.
`timescale 1ns / 1ps

module rigid_body_2d_integrator_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  rbi_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rbi_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [30:0]      csr_wdata
);

   logic [30:0]      time_step_ff;
   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;
   rbi_pkg::job_type q_wdata;
   rbi_pkg::job_type q_rdata;

   // Step register
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= 31'd1092;
      end else if (csr_we) begin
         time_step_ff <= csr_wdata;
      end
   end

   rbi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   rbi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .data_out (q_rdata),
      .empty    (q_empty)
   );

   rbi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .dt_i      (time_step_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_rdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/rbi_front.sv =====
// Front end: input register that takes bodies and splits loads into sign and magnitude.
// Depends on rbi_pkg; feeds rbi_queue.
`timescale 1ns / 1ps

module rbi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  rbi_pkg::req_type req_data,
   output logic             req_full,
   input  logic             q_full,
   output logic             q_push,
   output rbi_pkg::job_type q_data
);

   logic             fv_ff;
   logic             fv_in;
   rbi_pkg::job_type job_ff;
   rbi_pkg::job_type job_in;
   logic             accept;
   logic [2:0][31:0] loads;

   // Classify the incoming body
   always_comb begin
      loads           = {req_data.net_torque, req_data.force_y, req_data.force_x};
      job_in.op       = req_data.op;
      job_in.pos      = {req_data.angle, req_data.pos_y, req_data.pos_x};
      job_in.vel      = {req_data.ang_rate, req_data.vel_y, req_data.vel_x};
      job_in.divisor  = {req_data.body_inertia, req_data.body_mass, req_data.body_mass};
      for (int l = 0; l < 3; l++) begin
         job_in.load_neg[l] = loads[l][31];
         job_in.load_mag[l] = loads[l][31] ? (32'd0 - loads[l]) : loads[l];
         job_in.div_zero[l] = (job_in.divisor[l] == 31'd0);
      end
      job_in.zero = |job_in.div_zero;
   end

   // Hold the item until the queue has room
   assign req_full = fv_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = fv_ff && !q_full;
   assign q_data   = job_ff;
   assign fv_in    = accept || (fv_ff && q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

// ===== rtl/rbi_queue.sv =====
// Short first-in first-out queue of classified bodies between front and back.
// Depends on rbi_pkg for the entry type.
`timescale 1ns / 1ps

module rbi_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbi_pkg::job_type data_in,
   output logic             full,
   input  logic             pop,
   output rbi_pkg::job_type data_out,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rbi_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

// ===== rtl/rbi_div.sv =====
// One lane of the pipelined restoring divider: trunc(load * 2^16 / divisor), saturated.
// Depends on rbi_pkg; one quotient bit per stage, advanced by a shared enable.
`timescale 1ns / 1ps

module rbi_div (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        mag_i,
   input  logic               neg_i,
   input  logic [30:0]        divisor_i,
   input  logic               zero_i,
   output logic signed [31:0] acc_o,
   output logic               sat_o
);

   localparam int unsigned NS = rbi_pkg::DIV_STAGES;

   logic [30:0] rem_ff  [NS];
   logic [31:0] num_ff  [NS];
   logic [30:0] div_ff  [NS];
   logic [31:0] quo_ff  [NS+1];
   logic        neg_ff  [NS+1];
   logic        zero_ff [NS+1];
   logic        ovf_ff  [NS+1];
   logic [31:0] trial_w [NS];
   logic [31:0] diff_w  [NS];
   logic        ge_w    [NS];

   // Trial subtract of each stage
   always_comb begin
      for (int s = 0; s < NS; s++) begin
         trial_w[s] = {rem_ff[s], num_ff[s][31]};
         ge_w[s]    = (trial_w[s] >= {1'b0, div_ff[s]});
         diff_w[s]  = trial_w[s] - {1'b0, div_ff[s]};
      end
   end

   // Load the top dividend bits, then shift one quotient bit per stage
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= {15'd0, mag_i[31:16]};
         num_ff[0]  <= {mag_i[15:0], 16'd0};
         div_ff[0]  <= divisor_i;
         quo_ff[0]  <= '0;
         neg_ff[0]  <= neg_i;
         zero_ff[0] <= zero_i;
         ovf_ff[0]  <= !zero_i && ({15'd0, mag_i[31:16]} >= divisor_i);
         for (int s = 0; s < NS - 1; s++) begin
            rem_ff[s+1] <= ge_w[s] ? diff_w[s][30:0] : trial_w[s][30:0];
            num_ff[s+1] <= {num_ff[s][30:0], 1'b0};
            div_ff[s+1] <= div_ff[s];
         end
         for (int s = 0; s < NS; s++) begin
            quo_ff[s+1]  <= {quo_ff[s][30:0], ge_w[s]};
            neg_ff[s+1]  <= neg_ff[s];
            zero_ff[s+1] <= zero_ff[s];
            ovf_ff[s+1]  <= ovf_ff[s];
         end
      end
   end

   // Apply sign and clamp
   always_comb begin
      priority if (zero_ff[NS]) begin
         acc_o = '0;
         sat_o = 1'b0;
      end else if (ovf_ff[NS]) begin
         acc_o = neg_ff[NS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         sat_o = 1'b1;
      end else if (!neg_ff[NS]) begin
         acc_o = quo_ff[NS][31] ? 32'sh7FFF_FFFF : $signed(quo_ff[NS]);
         sat_o = quo_ff[NS][31];
      end else begin
         sat_o = (quo_ff[NS] > 32'h8000_0000);
         acc_o = sat_o ? 32'sh8000_0000 : $signed(32'd0 - quo_ff[NS]);
      end
   end

endmodule

// ===== rtl/rbi_back.sv =====
// Back end: three divider lanes, then step multiply, shift, add and clamp stages.
// Depends on rbi_pkg and rbi_div; the result register sits at the end of the pipe.
`timescale 1ns / 1ps

module rbi_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [30:0]      dt_i,
   input  logic             q_empty,
   output logic             q_pop,
   input  rbi_pkg::job_type q_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rbi_pkg::rsp_type rsp_data
);

   localparam int unsigned NS = rbi_pkg::DIV_STAGES;

   logic                 en;
   logic signed [31:0]   dt_s;
   logic                 vld_ff [NS+1];
   rbi_pkg::carry_type   car_ff [NS+1];
   logic signed [31:0]   div_acc [3];
   logic [2:0]           div_sat;

   logic                 a_vld_ff;
   rbi_pkg::carry_type   a_car_ff;
   logic signed [31:0]   a_acc_ff [3];
   logic                 a_sat_ff;

   logic                 m1_vld_ff;
   rbi_pkg::carry_type   m1_car_ff;
   logic signed [63:0]   m1_pav_ff [3];
   logic signed [63:0]   m1_pvd_ff [3];
   logic                 m1_sat_ff;

   logic                 m2_vld_ff;
   rbi_pkg::carry_type   m2_car_ff;
   logic signed [31:0]   m2_dv_ff [3];
   logic signed [47:0]   m2_dp_ff [3];
   logic                 m2_sat_ff;
   logic signed [63:0]   m2_dv_in [3];
   logic                 m2_sat_in;

   logic                 m3_vld_ff;
   rbi_pkg::carry_type   m3_car_ff;
   logic signed [47:0]   m3_dp_ff [3];
   logic signed [47:0]   m3_half_ff [3];
   logic signed [31:0]   m3_nv_ff [3];
   logic                 m3_sat_ff;
   logic signed [63:0]   m3_half_in [3];
   logic signed [63:0]   m3_nv_in [3];
   logic                 m3_sat_in;

   logic                 out_vld_ff;
   rbi_pkg::rsp_type     out_ff;
   rbi_pkg::rsp_type     out_in;
   logic signed [63:0]   m4_sum [3];
   logic                 m4_sat;

   // Whole pipe moves unless the result register is held
   assign en        = !out_vld_ff || rsp_pop;
   assign q_pop     = en && !q_empty;
   assign dt_s      = $signed({1'b0, dt_i});
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      rbi_div u_div (
         .clock     (clock),
         .en        (en),
         .mag_i     (q_data.load_mag[l]),
         .neg_i     (q_data.load_neg[l]),
         .divisor_i (q_data.divisor[l]),
         .zero_i    (q_data.div_zero[l]),
         .acc_o     (div_acc[l]),
         .sat_o     (div_sat[l])
      );
   end

   // Valid bits of every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NS; s++) begin
            vld_ff[s] <= 1'b0;
         end
         a_vld_ff   <= 1'b0;
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         m3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= !q_empty;
         for (int s = 0; s < NS; s++) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         a_vld_ff   <= vld_ff[NS];
         m1_vld_ff  <= a_vld_ff;
         m2_vld_ff  <= m1_vld_ff;
         m3_vld_ff  <= m2_vld_ff;
         out_vld_ff <= m3_vld_ff;
      end
   end

   // Carry state in step with the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         car_ff[0].op   <= q_data.op;
         car_ff[0].zero <= q_data.zero;
         car_ff[0].pos  <= q_data.pos;
         car_ff[0].vel  <= q_data.vel;
         for (int s = 0; s < NS; s++) begin
            car_ff[s+1] <= car_ff[s];
         end
      end
   end

   // Stage computations
   always_comb begin
      m2_sat_in = m1_sat_ff;
      for (int l = 0; l < 3; l++) begin
         m2_dv_in[l] = m1_pav_ff[l] >>> 16;
         m2_sat_in   = m2_sat_in | rbi_pkg::ovf32(m2_dv_in[l]);
      end
      m3_sat_in = m2_sat_ff;
      for (int l = 0; l < 3; l++) begin
         m3_half_in[l] = (m2_dv_ff[l] * dt_s) >>> 17;
         m3_nv_in[l]   = 64'($signed(m2_car_ff.vel[l])) + 64'(m2_dv_ff[l]);
         m3_sat_in     = m3_sat_in | rbi_pkg::ovf32(m3_nv_in[l]);
      end
      m4_sat = m3_sat_ff;
      for (int l = 0; l < 3; l++) begin
         m4_sum[l] = 64'($signed(m3_car_ff.pos[l])) + 64'(m3_dp_ff[l])
                   + (m3_car_ff.op ? 64'(m3_half_ff[l]) : 64'sd0);
         m4_sat    = m4_sat | rbi_pkg::ovf32(m4_sum[l]);
      end
      out_in.next_pos_x    = rbi_pkg::sat32(m4_sum[0]);
      out_in.next_pos_y    = rbi_pkg::sat32(m4_sum[1]);
      out_in.next_angle    = rbi_pkg::sat32(m4_sum[2]);
      out_in.next_vel_x    = m3_nv_ff[0];
      out_in.next_vel_y    = m3_nv_ff[1];
      out_in.next_ang_rate = m3_nv_ff[2];
      priority if (m3_car_ff.zero) begin
         out_in.status = rbi_pkg::STAT_ZERO;
      end else if (m4_sat) begin
         out_in.status = rbi_pkg::STAT_SAT;
      end else begin
         out_in.status = rbi_pkg::STAT_OK;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         a_car_ff <= car_ff[NS];
         a_sat_ff <= |div_sat;
         for (int l = 0; l < 3; l++) begin
            a_acc_ff[l] <= div_acc[l];
         end

         m1_car_ff <= a_car_ff;
         m1_sat_ff <= a_sat_ff;
         for (int l = 0; l < 3; l++) begin
            m1_pav_ff[l] <= a_acc_ff[l] * dt_s;
            m1_pvd_ff[l] <= $signed(a_car_ff.vel[l]) * dt_s;
         end

         m2_car_ff <= m1_car_ff;
         m2_sat_ff <= m2_sat_in;
         for (int l = 0; l < 3; l++) begin
            m2_dv_ff[l] <= rbi_pkg::sat32(m2_dv_in[l]);
            m2_dp_ff[l] <= 48'(m1_pvd_ff[l] >>> 16);
         end

         m3_car_ff <= m2_car_ff;
         m3_sat_ff <= m3_sat_in;
         for (int l = 0; l < 3; l++) begin
            m3_dp_ff[l]   <= m2_dp_ff[l];
            m3_half_ff[l] <= 48'(m3_half_in[l]);
            m3_nv_ff[l]   <= rbi_pkg::sat32(m3_nv_in[l]);
         end

         out_ff <= out_in;
      end
   end

   // A held result stays put until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_pop |=> out_vld_ff && $stable(out_ff))
      else $error("result changed while held");

   // A body in the last step stage reaches the result register when the pipe moves
   a_drain: assert property (@(posedge clock) disable iff (reset)
      m3_vld_ff && en |=> out_vld_ff)
      else $error("item lost before result register");

   // A zero divisor yields zero acceleration on its lanes
   a_zero: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && a_car_ff.zero |->
         ((a_acc_ff[0] == 32'sd0) && (a_acc_ff[1] == 32'sd0)) || (a_acc_ff[2] == 32'sd0))
      else $error("zero divisor with nonzero acceleration");

endmodule
